// ===== rtl/core/line_fit_gradient_descent_assert.svh =====
// Assertion macros for the line fitter checker.
`ifndef LINE_FIT_GRADIENT_DESCENT_ASSERT_SVH
`define LINE_FIT_GRADIENT_DESCENT_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define LFGD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A stalled transaction keeps valid up and its payload unchanged.
`define LFGD_ASSERT_STALL(name, vld, rdy, dat) \
  `LFGD_ASSERT(name, (vld && !rdy) |=> (vld && $stable(dat)), "stalled transaction changed")

`endif

// ===== rtl/core/lfgd_pkg.sv =====
`default_nettype none

package lfgd_pkg;

  localparam int unsigned PADDR_W = 5;
  localparam logic [63:0] LOSS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  // register reset values
  localparam logic [16:0] RST_LEARNING_RATE       = 17'd6554;
  localparam logic [16:0] RST_STOP_TOLERANCE      = 17'd7;
  localparam logic [16:0] RST_SLOPE_DIFF_STEP     = 17'd655;
  localparam logic [16:0] RST_INTERCEPT_DIFF_STEP = 17'd655;
  localparam logic [31:0] RST_START_SLOPE         = 32'd137626;
  localparam logic [31:0] RST_START_INTERCEPT     = 32'hFFFF_3333;
  localparam logic [15:0] RST_ITERATION_LIMIT     = 16'd1000;

  typedef enum logic [2:0] {
    REG_LEARNING_RATE       = 3'd0,
    REG_STOP_TOLERANCE      = 3'd1,
    REG_SLOPE_DIFF_STEP     = 3'd2,
    REG_INTERCEPT_DIFF_STEP = 3'd3,
    REG_START_SLOPE         = 3'd4,
    REG_START_INTERCEPT     = 3'd5,
    REG_ITERATION_LIMIT     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [31:0] fit_slope;
    logic signed [31:0] fit_intercept;
    logic [15:0]        iterations_used;
    logic               converged;
    logic               loss_overflow;
  } result_t;

  typedef struct packed {
    logic [16:0]        learning_rate;
    logic [16:0]        stop_tolerance;
    logic [16:0]        slope_diff_step;
    logic [16:0]        intercept_diff_step;
    logic signed [31:0] start_slope;
    logic signed [31:0] start_intercept;
    logic [15:0]        iteration_limit;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT, ST_ITER, ST_DEN, ST_DEN2, ST_RD, ST_MULAX, ST_RES,
    ST_SQ1, ST_SQ2, ST_SQ3, ST_SQ4, ST_DIVL, ST_DIVLW, ST_ACC, ST_LDONE,
    ST_GDIV, ST_GDIVW, ST_GSAT, ST_GMUL, ST_GUPD,
    ST_CV1, ST_CV2, ST_CV3, ST_CV4, ST_EMIT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_ITER, OP_DEN, OP_DEN2, OP_MULAX, OP_RES,
    OP_SQ1, OP_SQ2, OP_SQ3, OP_SQ4, OP_DIVL, OP_ACC, OP_LDONE,
    OP_GDIV, OP_GSAT, OP_GMUL, OP_GUPD,
    OP_CV1, OP_CV2, OP_CV3, OP_CV4, OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    LOSS_HERE  = 2'd0,
    LOSS_SLOPE = 2'd1,
    LOSS_ICPT  = 2'd2
  } loss_sel_e;

  typedef struct packed {
    op_e       op;
    loss_sel_e lsel;
    logic      gsel;   // 0: slope, 1: intercept
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic idx_last;
    logic div_done;
    logic fit_stop;
    logic out_free;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = 68'sd2147483647;
    lo = -68'sd2147483648;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lfgd_if.sv =====
`default_nettype none

interface lfgd_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfgd_div.sv =====
`default_nettype none

// 128/64 restoring divider, one quotient bit per cycle, saturating at LOSS_MAX.
module lfgd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_hi_i,
  input  logic [63:0] num_lo_i,
  input  logic [63:0] den_i,
  output logic [63:0] quo_o,
  output logic        ovf_o,
  output logic        done_o
);
  import lfgd_pkg::*;

  logic        busy_q, done_q, sat_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q, lo_q, quo_q, den_q;
  logic [64:0] trial;
  logic        ge;

  assign trial = {rem_q, lo_q[63]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      cnt_q <= 6'd63;
      if (num_hi_i >= den_i) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
        sat_q  <= 1'b1;
      end else begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        sat_q  <= 1'b0;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_hi_i;
      lo_q  <= num_lo_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? 64'(trial - {1'b0, den_q}) : trial[63:0];
      lo_q  <= {lo_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign ovf_o  = sat_q || quo_q[63];
  assign quo_o  = ovf_o ? LOSS_MAX : quo_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== rtl/core/lfgd_ctrl.sv =====
`default_nettype none

module lfgd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  input  lfgd_pkg::status_t status_i,
  output logic              in_ready_o,
  output lfgd_pkg::cmd_t    cmd_o
);
  import lfgd_pkg::*;

  state_e    state_q, state_d;
  loss_sel_e lsel_q;
  logic      gsel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lsel_q  <= LOSS_HERE;
      gsel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_ITER: begin
          lsel_q <= LOSS_HERE;
          gsel_q <= 1'b0;
        end
        ST_LDONE: begin
          case (lsel_q)
            LOSS_HERE:  lsel_q <= LOSS_SLOPE;
            LOSS_SLOPE: lsel_q <= LOSS_ICPT;
            default:    lsel_q <= LOSS_HERE;
          endcase
        end
        ST_GUPD: gsel_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i && in_last_i) state_d = ST_INIT;
      ST_INIT:   state_d = ST_ITER;
      ST_ITER:   state_d = ST_DEN;
      ST_DEN:    state_d = ST_DEN2;
      ST_DEN2:   state_d = status_i.count_zero ? ST_LDONE : ST_RD;
      ST_RD:     state_d = ST_MULAX;
      ST_MULAX:  state_d = ST_RES;
      ST_RES:    state_d = ST_SQ1;
      ST_SQ1:    state_d = ST_SQ2;
      ST_SQ2:    state_d = ST_SQ3;
      ST_SQ3:    state_d = ST_SQ4;
      ST_SQ4:    state_d = ST_DIVL;
      ST_DIVL:   state_d = ST_DIVLW;
      ST_DIVLW:  if (status_i.div_done) state_d = ST_ACC;
      ST_ACC:    state_d = status_i.idx_last ? ST_LDONE : ST_RD;
      ST_LDONE:  state_d = (lsel_q == LOSS_ICPT) ? ST_GDIV : ST_DEN;
      ST_GDIV:   state_d = ST_GDIVW;
      ST_GDIVW:  if (status_i.div_done) state_d = ST_GSAT;
      ST_GSAT:   state_d = ST_GMUL;
      ST_GMUL:   state_d = ST_GUPD;
      ST_GUPD:   state_d = gsel_q ? ST_CV1 : ST_GDIV;
      ST_CV1:    state_d = ST_CV2;
      ST_CV2:    state_d = ST_CV3;
      ST_CV3:    state_d = ST_CV4;
      ST_CV4:    state_d = status_i.fit_stop ? ST_EMIT : ST_ITER;
      ST_EMIT:   if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.lsel = lsel_q;
    cmd_o.gsel = gsel_q;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_INIT:  cmd_o.op = OP_INIT;
      ST_ITER:  cmd_o.op = OP_ITER;
      ST_DEN:   cmd_o.op = OP_DEN;
      ST_DEN2:  cmd_o.op = OP_DEN2;
      ST_MULAX: cmd_o.op = OP_MULAX;
      ST_RES:   cmd_o.op = OP_RES;
      ST_SQ1:   cmd_o.op = OP_SQ1;
      ST_SQ2:   cmd_o.op = OP_SQ2;
      ST_SQ3:   cmd_o.op = OP_SQ3;
      ST_SQ4:   cmd_o.op = OP_SQ4;
      ST_DIVL:  cmd_o.op = OP_DIVL;
      ST_ACC:   cmd_o.op = OP_ACC;
      ST_LDONE: cmd_o.op = OP_LDONE;
      ST_GDIV:  cmd_o.op = OP_GDIV;
      ST_GSAT:  cmd_o.op = OP_GSAT;
      ST_GMUL:  cmd_o.op = OP_GMUL;
      ST_GUPD:  cmd_o.op = OP_GUPD;
      ST_CV1:   cmd_o.op = OP_CV1;
      ST_CV2:   cmd_o.op = OP_CV2;
      ST_CV3:   cmd_o.op = OP_CV3;
      ST_CV4:   cmd_o.op = OP_CV4;
      ST_EMIT:  cmd_o.op = status_i.out_free ? OP_EMIT : OP_NONE;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/lfgd_dp.sv =====
`default_nettype none

module lfgd_dp #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfgd_pkg::cfg_t    cfg_i,
  input  logic              in_fire_i,
  input  lfgd_pkg::point_t  point_i,
  input  lfgd_pkg::cmd_t    cmd_i,
  input  logic              out_ready_i,
  output lfgd_pkg::status_t status_o,
  output logic              out_valid_o,
  output lfgd_pkg::result_t result_o
);
  import lfgd_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic [63:0] DEN_ONE = 64'd1 << (2 * FRAC_BITS);
  localparam logic signed [67:0] RND = (68'sd1 <<< FRAC_BITS) - 68'sd1;

  // point store
  logic [31:0] x_mem [MAX_POINTS];
  logic [31:0] y_mem [MAX_POINTS];
  logic [31:0] rd_x_q, rd_y_q;

  logic [CW-1:0] count_q, idx_q;
  logic signed [31:0] cur_a_q, cur_b_q, prev_a_q, prev_b_q;
  logic [15:0]  iter_q;
  logic         ovf_q, conv_q, diff_neg_q, out_valid_q;
  logic [63:0]  den_q, sum_q, ur_q, l0_q, la_q, lb_q;
  logic [127:0] acc_q;
  logic signed [67:0] prod_q;
  logic signed [31:0] g_q;
  logic [64:0]  dist_q;
  result_t      result_q;

  // point under evaluation
  logic signed [31:0] a_eval, b_eval;
  logic signed [67:0] a_shift, b_shift;
  logic [31:0]  ua;
  logic [16:0]  step_a, step_b;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic signed [63:0] ymb, resid, diff;
  logic [63:0]  abs_diff;
  logic signed [33:0] da, db;
  logic signed [67:0] gq_s, adj, upd, new_v, v_old;
  logic [64:0]  term_sum;

  // divider
  logic        div_start, div_ovf, div_done;
  logic [63:0] div_hi, div_lo, div_den, div_quo;

  assign step_a  = (cfg_i.slope_diff_step == '0) ? 17'd1 : cfg_i.slope_diff_step;
  assign step_b  = (cfg_i.intercept_diff_step == '0) ? 17'd1 : cfg_i.intercept_diff_step;
  assign a_shift = 68'(prev_a_q) + 68'($signed({1'b0, cfg_i.slope_diff_step}));
  assign b_shift = 68'(prev_b_q) + 68'($signed({1'b0, cfg_i.intercept_diff_step}));
  assign a_eval  = (cmd_i.lsel == LOSS_SLOPE) ? sat32(a_shift) : prev_a_q;
  assign b_eval  = (cmd_i.lsel == LOSS_ICPT) ? sat32(b_shift) : prev_b_q;
  assign ua      = a_eval[31] ? (~a_eval + 32'd1) : a_eval;

  assign ymb   = 64'(signed'(rd_y_q)) - 64'(b_eval);
  assign resid = (ymb <<< FRAC_BITS) - $signed(prod_q[63:0]);

  assign diff     = $signed(cmd_i.gsel ? lb_q : la_q) - $signed(l0_q);
  assign abs_diff = diff[63] ? 64'(-diff) : diff;

  assign da = 34'(cur_a_q) - 34'(prev_a_q);
  assign db = 34'(cur_b_q) - 34'(prev_b_q);

  assign gq_s  = diff_neg_q ? -$signed({4'b0, div_quo}) : $signed({4'b0, div_quo});
  assign adj   = prod_q + (prod_q[67] ? RND : 68'sd0);
  assign upd   = adj >>> FRAC_BITS;
  assign v_old = cmd_i.gsel ? 68'(prev_b_q) : 68'(prev_a_q);
  assign new_v = v_old - upd;

  assign term_sum = {1'b0, sum_q} + {1'b0, div_quo};

  // shared multiplier
  always_comb begin
    case (cmd_i.op)
      OP_DEN: begin
        mul_a = $signed({2'b0, ua});
        mul_b = $signed({2'b0, ua});
      end
      OP_MULAX: begin
        mul_a = 34'(a_eval);
        mul_b = 34'(signed'(rd_x_q));
      end
      OP_SQ1: begin
        mul_a = $signed({2'b0, ur_q[31:0]});
        mul_b = $signed({2'b0, ur_q[31:0]});
      end
      OP_SQ2: begin
        mul_a = $signed({2'b0, ur_q[63:32]});
        mul_b = $signed({2'b0, ur_q[31:0]});
      end
      OP_SQ3: begin
        mul_a = $signed({2'b0, ur_q[63:32]});
        mul_b = $signed({2'b0, ur_q[63:32]});
      end
      OP_GMUL: begin
        mul_a = $signed({17'b0, cfg_i.learning_rate});
        mul_b = 34'(g_q);
      end
      OP_CV1: begin
        mul_a = da;
        mul_b = da;
      end
      OP_CV2: begin
        mul_a = db;
        mul_b = db;
      end
      OP_CV3: begin
        mul_a = $signed({17'b0, cfg_i.stop_tolerance});
        mul_b = $signed({17'b0, cfg_i.stop_tolerance});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign div_start = (cmd_i.op == OP_DIVL) || (cmd_i.op == OP_GDIV);
  assign div_hi    = (cmd_i.op == OP_DIVL) ? acc_q[127:64] : 64'd0;
  assign div_lo    = (cmd_i.op == OP_DIVL) ? acc_q[63:0] : abs_diff;
  assign div_den   = (cmd_i.op == OP_DIVL) ? den_q
                   : {47'b0, (cmd_i.gsel ? step_b : step_a)};

  lfgd_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_hi_i (div_hi),
    .num_lo_i (div_lo),
    .den_i    (div_den),
    .quo_o    (div_quo),
    .ovf_o    (div_ovf),
    .done_o   (div_done)
  );

  // store: written on accepted points, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_fire_i && (count_q < CW'(MAX_POINTS))) begin
      x_mem[count_q[AW-1:0]] <= point_i.point_x;
      y_mem[count_q[AW-1:0]] <= point_i.point_y;
    end
    rd_x_q <= x_mem[idx_q[AW-1:0]];
    rd_y_q <= y_mem[idx_q[AW-1:0]];
  end

  // control and fit state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      cur_a_q     <= '0;
      cur_b_q     <= '0;
      prev_a_q    <= '0;
      prev_b_q    <= '0;
      iter_q      <= '0;
      ovf_q       <= 1'b0;
      conv_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire_i && (count_q < CW'(MAX_POINTS))) begin
        count_q <= count_q + CW'(1);
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_INIT: begin
          cur_a_q <= cfg_i.start_slope;
          cur_b_q <= cfg_i.start_intercept;
          iter_q  <= '0;
          ovf_q   <= 1'b0;
        end
        OP_ITER: begin
          prev_a_q <= cur_a_q;
          prev_b_q <= cur_b_q;
        end
        OP_DEN2: idx_q <= '0;
        OP_ACC: begin
          idx_q <= idx_q + CW'(1);
          if (div_ovf || (term_sum > {1'b0, LOSS_MAX})) begin
            ovf_q <= 1'b1;
          end
        end
        OP_GUPD: begin
          if (cmd_i.gsel) begin
            cur_b_q <= sat32(new_v);
          end else begin
            cur_a_q <= sat32(new_v);
          end
        end
        OP_CV3: iter_q <= iter_q + 16'd1;
        OP_CV4: conv_q <= status_o.fit_stop && (dist_q <= {31'b0, prod_q[33:0]});
        OP_EMIT: begin
          out_valid_q <= 1'b1;
          count_q     <= '0;
        end
        default: ;
      endcase
    end
  end

  // arithmetic registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    case (cmd_i.op)
      OP_DEN2: begin
        den_q <= prod_q[63:0] + DEN_ONE;
        sum_q <= '0;
      end
      OP_RES:  ur_q  <= resid[63] ? 64'(-resid) : resid;
      OP_SQ2:  acc_q <= {64'b0, prod_q[63:0]};
      OP_SQ3:  acc_q <= acc_q + ({64'b0, prod_q[63:0]} << 33);
      OP_SQ4:  acc_q <= acc_q + {prod_q[63:0], 64'b0};
      OP_ACC:  sum_q <= (term_sum > {1'b0, LOSS_MAX}) ? LOSS_MAX : term_sum[63:0];
      OP_LDONE: begin
        case (cmd_i.lsel)
          LOSS_HERE:  l0_q <= sum_q;
          LOSS_SLOPE: la_q <= sum_q;
          default:    lb_q <= sum_q;
        endcase
      end
      OP_GDIV: diff_neg_q <= diff[63];
      OP_GSAT: g_q <= sat32(gq_s);
      OP_CV2:  dist_q <= {1'b0, prod_q[63:0]};
      OP_CV3:  dist_q <= dist_q + {1'b0, prod_q[63:0]};
      OP_EMIT: begin
        result_q.fit_slope       <= cur_a_q;
        result_q.fit_intercept   <= cur_b_q;
        result_q.iterations_used <= iter_q;
        result_q.converged       <= conv_q;
        result_q.loss_overflow   <= ovf_q;
      end
      default: ;
    endcase
  end

  assign status_o.count_zero = (count_q == '0);
  assign status_o.idx_last   = ((idx_q + CW'(1)) == count_q);
  assign status_o.div_done   = div_done;
  assign status_o.fit_stop   = (dist_q <= {31'b0, prod_q[33:0]})
                            || (iter_q >= cfg_i.iteration_limit);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// ===== rtl/core/line_fit_gradient_descent.sv =====
// Line fitter: total least squares by gradient descent, Q16.16 fixed point.
// point_i (valid/ready) takes one (x, y, last_point) transaction per cycle
// while the block is idle; points fill a store of MAX_POINTS entries and
// extra points are dropped. A transaction with last_point set starts a fit
// over the stored points; point_i stays not-ready until the fit is done.
// Each descent iteration evaluates the loss three times (here, slope step,
// intercept step); the work per point is bound by the bit-serial divider,
// and the fit runs until the step is within tolerance or the iteration
// limit is hit. The result goes to an output register on fit_o; if the
// receiver stalls, point_i accepts new points again and a later fit waits
// for the register to drain before finishing. Registers are written over
// APB (byte address 4*index); the user must write them only while idle,
// as the block itself does not enforce it. Reset restores the register
// defaults, empties the store and drops any pending result.
`default_nettype none

module line_fit_gradient_descent #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lfgd_if.sink                         point_i,
  lfgd_if.source                       fit_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfgd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import lfgd_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;
  result_t result;
  point_t  point;
  logic    in_ready, in_fire, out_valid, cfg_wr;

  // APB register file; pready is tied high, writes complete in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_rate       <= RST_LEARNING_RATE;
      cfg_q.stop_tolerance      <= RST_STOP_TOLERANCE;
      cfg_q.slope_diff_step     <= RST_SLOPE_DIFF_STEP;
      cfg_q.intercept_diff_step <= RST_INTERCEPT_DIFF_STEP;
      cfg_q.start_slope         <= RST_START_SLOPE;
      cfg_q.start_intercept     <= RST_START_INTERCEPT;
      cfg_q.iteration_limit     <= RST_ITERATION_LIMIT;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[4:2]))
        REG_LEARNING_RATE:       cfg_q.learning_rate       <= pwdata[16:0];
        REG_STOP_TOLERANCE:      cfg_q.stop_tolerance      <= pwdata[16:0];
        REG_SLOPE_DIFF_STEP:     cfg_q.slope_diff_step     <= pwdata[16:0];
        REG_INTERCEPT_DIFF_STEP: cfg_q.intercept_diff_step <= pwdata[16:0];
        REG_START_SLOPE:         cfg_q.start_slope         <= pwdata;
        REG_START_INTERCEPT:     cfg_q.start_intercept     <= pwdata;
        REG_ITERATION_LIMIT:     cfg_q.iteration_limit     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[4:2]))
      REG_LEARNING_RATE:       prdata = {15'b0, cfg_q.learning_rate};
      REG_STOP_TOLERANCE:      prdata = {15'b0, cfg_q.stop_tolerance};
      REG_SLOPE_DIFF_STEP:     prdata = {15'b0, cfg_q.slope_diff_step};
      REG_INTERCEPT_DIFF_STEP: prdata = {15'b0, cfg_q.intercept_diff_step};
      REG_START_SLOPE:         prdata = cfg_q.start_slope;
      REG_START_INTERCEPT:     prdata = cfg_q.start_intercept;
      REG_ITERATION_LIMIT:     prdata = {16'b0, cfg_q.iteration_limit};
      default:                 prdata = '0;
    endcase
  end

  // input channel
  assign point         = point_i.data;
  assign point_i.ready = in_ready;
  assign in_fire       = point_i.valid && in_ready;

  lfgd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (point_i.valid),
    .in_last_i  (point.last_point),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  lfgd_dp #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_fire_i   (in_fire),
    .point_i     (point),
    .cmd_i       (cmd),
    .out_ready_i (fit_o.ready),
    .status_o    (status),
    .out_valid_o (out_valid),
    .result_o    (result)
  );

  // result channel, driven straight from the output register
  assign fit_o.valid = out_valid;
  assign fit_o.data  = result;

endmodule

`default_nettype wire

// ===== rtl/core/lfgd_chk.sv =====
`default_nettype none
`include "line_fit_gradient_descent_assert.svh"

module lfgd_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input lfgd_pkg::result_t out_data_i
);
  import lfgd_pkg::*;

  `LFGD_ASSERT_STALL(a_out_hold, out_valid_i, out_ready_i, out_data_i)
  `LFGD_ASSERT(a_iter_nonzero, out_valid_i |-> (out_data_i.iterations_used != '0), "zero iterations")
  `LFGD_ASSERT(a_valid_known, !$isunknown(out_valid_i), "result valid unknown")

endmodule

bind line_fit_gradient_descent lfgd_chk u_lfgd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (fit_o.valid),
  .out_ready_i (fit_o.ready),
  .out_data_i  (fit_o.data)
);

`default_nettype wire
